[rtl/core/bdrg_pkg.sv]
// ----------------------------------------------------------------------------
// bdrg_pkg
// Shared types and constants of the distance relaxation block: payload
// structs of both channels, the work item between front and back, and the
// back-end state encoding.
// ----------------------------------------------------------------------------
package bdrg_pkg;

    // Store geometry; WORDS, LANES and PE_COUNT * LANES are powers of two
    localparam int WORDS       = 4096;
    localparam int LANES       = 8;
    localparam int PE_COUNT    = 16;
    localparam int QUEUE_DEPTH = 2;

    // Field widths
    localparam int DIST_W  = 8;
    localparam int VTX_W   = 24;
    localparam int PE_W    = 4;
    localparam int IDX_W   = 16;
    localparam int CAND_W  = DIST_W + 1;
    localparam int DIFF_W  = VTX_W + 1;
    localparam int LANE_W  = $clog2(LANES);
    localparam int ADDR_W  = $clog2(WORDS);
    localparam int WORD_W  = LANES * DIST_W;
    localparam int SHIFT_W = $clog2(PE_COUNT * LANES);

    // Input item: message bits 31..24 distance, 23..0 vertex
    typedef struct packed {
        logic [DIST_W-1:0] source_distance;
        logic [VTX_W-1:0]  dest_vertex;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic              updated;
        logic [DIST_W-1:0] new_distance;
    } t_out_item;

    // Classified item handed from front to back
    typedef struct packed {
        logic [ADDR_W-1:0] word;
        logic [LANE_W-1:0] lane;
        logic [CAND_W-1:0] cand;
    } t_work;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_READ,
        ST_MODIFY
    } t_state;

endpackage

[rtl/core/bdrg_ram.sv]
// ----------------------------------------------------------------------------
// bdrg_ram
// Generic single-port RAM: one address per cycle, write or read, with the
// read data registered (old contents returned on a write cycle).
// ----------------------------------------------------------------------------
module bdrg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bdrg_front.sv]
// ----------------------------------------------------------------------------
// bdrg_front
// Front end: holds the processing-element id and turns each incoming item
// into a store word address, a byte lane and the 9-bit candidate distance.
// ----------------------------------------------------------------------------
module bdrg_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [bdrg_pkg::PE_W-1:0] i_cfg_data,
    input  bdrg_pkg::t_in_item       i_item,
    output bdrg_pkg::t_work          o_work
);
    import bdrg_pkg::*;

    logic [PE_W-1:0]   r_pe_id;
    logic [DIFF_W-1:0] diff;
    logic [IDX_W-1:0]  idx;

    // Hold the processing-element id
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pe_id <= '0;
        end else if (i_cfg_we) begin
            r_pe_id <= i_cfg_data;
        end
    end

    // Local index: vertices below the id map to slot zero
    always_comb begin
        diff = {1'b0, i_item.dest_vertex} - DIFF_W'(r_pe_id);
        idx  = diff[DIFF_W-1] ? '0 : diff[SHIFT_W +: IDX_W];
    end

    // Split the index into word and lane, form the candidate
    always_comb begin
        o_work.word = idx[LANE_W +: ADDR_W];
        o_work.lane = idx[LANE_W-1:0];
        o_work.cand = {1'b0, i_item.source_distance} + CAND_W'(1);
    end

endmodule

[rtl/core/bdrg_queue.sv]
// ----------------------------------------------------------------------------
// bdrg_queue
// Small FIFO of classified items between front and back so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
module bdrg_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bdrg_pkg::t_work  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output bdrg_pkg::t_work  o_item
);
    import bdrg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_work             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;

    // Advance pointers with wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

endmodule

[rtl/core/bdrg_back.sv]
// ----------------------------------------------------------------------------
// bdrg_back
// Back end: clears the store after reset, then runs a read-modify-write on
// the single-port store for each queued item and loads the result register.
// ----------------------------------------------------------------------------
module bdrg_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  bdrg_pkg::t_work             i_q_item,
    output logic                        o_q_pop,
    output logic                        o_clearing,
    output logic                        o_ram_we,
    output logic [bdrg_pkg::ADDR_W-1:0] o_ram_addr,
    output logic [bdrg_pkg::WORD_W-1:0] o_ram_wdata,
    input  logic [bdrg_pkg::WORD_W-1:0] i_ram_rdata,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bdrg_pkg::t_out_item         o_out_data
);
    import bdrg_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_out_valid;
    t_out_item         r_out_data;
    logic              out_free;
    logic              load;
    logic [DIST_W-1:0] stored;
    logic              update;
    logic [WORD_W-1:0] merged;

    assign out_free = !r_out_valid || !i_out_stall;

    // Pick the addressed byte and compare at nine bits
    always_comb begin
        stored = '0;
        for (int l = 0; l < LANES; l++) begin
            if (i_q_item.lane == LANE_W'(l)) begin
                stored = i_ram_rdata[l*DIST_W +: DIST_W];
            end
        end
        update = (i_q_item.cand < {1'b0, stored});
    end

    // Replace the addressed byte with the candidate
    always_comb begin
        merged = i_ram_rdata;
        for (int l = 0; l < LANES; l++) begin
            if (i_q_item.lane == LANE_W'(l)) begin
                merged[l*DIST_W +: DIST_W] = i_q_item.cand[DIST_W-1:0];
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(WORDS - 1)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (i_q_valid) begin
                    n_state = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                if (out_free) begin
                    n_state = ST_READ;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Outputs toward store, queue and result register
    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_addr  = i_q_item.word;
        o_ram_wdata = merged;
        o_q_pop     = 1'b0;
        load        = 1'b0;
        o_clearing  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_addr  = r_clr_addr;
                o_ram_wdata = '1;
                o_clearing  = 1'b1;
            end
            ST_READ: begin
                o_ram_we = 1'b0;
            end
            ST_MODIFY: begin
                o_ram_we = update && out_free;
                o_q_pop  = out_free;
                load     = out_free;
            end
            default: begin
                o_clearing = 1'b1;
            end
        endcase
    end

    // State and clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // Result register: load when free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data.updated      <= update;
            r_out_data.new_distance <= update ? i_q_item.cand[DIST_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/core/bfs_distance_relax_gather.sv]
// ----------------------------------------------------------------------------
// bfs_distance_relax_gather
// Edge relaxation for one processing element: lowers a stored vertex
// distance to source distance + 1 when that is smaller.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / i_in_data / o_in_stall; an item is taken at a
//   clock edge with valid high and stall low. Output channel: o_out_valid /
//   o_out_data / i_out_stall, one result per item, in order.
//   Configuration: i_cfg_valid / i_cfg_data / o_cfg_ready writes pe_id; ready
//   is always high. Write it only while the block is idle.
// Reset:
//   i_rst_n low clears control and pe_id. After release the store is swept to
//   255 (infinite) one word per cycle, all 4096 words, with o_in_stall held high.
// Flow:
//   Each item is finished before the next: the single-port store is read
//   in ST_READ, then in ST_MODIFY the word is written back if the candidate
//   is smaller and the result register loads. A two-entry queue takes a
//   short burst; while i_out_stall holds the result register full, the back
//   end waits and the front keeps taking items until the queue fills.
// ----------------------------------------------------------------------------
module bfs_distance_relax_gather (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [bdrg_pkg::PE_W-1:0]  i_cfg_data,
    output logic                       o_cfg_ready,
    input  logic                       i_in_valid,
    input  bdrg_pkg::t_in_item         i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output bdrg_pkg::t_out_item        o_out_data,
    input  logic                       i_out_stall
);
    import bdrg_pkg::*;

    t_work             front_work;
    t_work             q_item;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic              push;
    logic              clearing;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full || clearing;
    assign push        = i_in_valid && !o_in_stall;

    bdrg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .o_work     (front_work)
    );

    bdrg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_work),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    bdrg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    bdrg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    // No item enters while the store is being swept
    a_no_push_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !push)
        else $error("item accepted during store clear");

    // A result without update carries zero distance
    a_zero_when_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.updated) |-> (o_out_data.new_distance == '0))
        else $error("nonzero distance on a result without update");

    // A written distance is at least one
    a_update_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.updated) |-> (o_out_data.new_distance != '0))
        else $error("update reported with zero distance");

    // The store is written only when a result is produced or during the clear
    a_write_with_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (clearing || q_pop))
        else $error("store write without a finished item");
`endif

endmodule

[sim/bfs_distance_relax_gather_tb.sv]
// ----------------------------------------------------------------------------
// bfs_distance_relax_gather_tb
// Self-checking bench for the distance relaxation block. A shadow copy of the
// distance store and of pe_id predicts each result when its item is accepted.
// The block's results are compared in order against those predictions.
// Directed cases come first: vertices below pe_id, an unreachable source,
// equal distances, the top vertex id and index aliasing. Three random phases
// follow, each with its own pe_id and its own pattern of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module bfs_distance_relax_gather_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdrg_pkg::*;

    localparam int SLOT_SPAN = PE_COUNT * LANES;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      cfg_valid = 1'b0;
    logic [PE_W-1:0] cfg_data = '0;
    logic      cfg_ready;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall = 1'b0;

    // Shadow state of the block
    logic [WORD_W-1:0] dist_shadow [WORDS];
    logic [PE_W-1:0]   pe_shadow;
    t_out_item         expected_relax [$];

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic [VTX_W-1:0] hot_vertex [16];

    bfs_distance_relax_gather u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    // Clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Hard limit on run length
    initial begin
        #5_000_000;
        $display("bfs_distance_relax_gather_tb NOT OK");
        $finish;
    end

    // Relax one slot of the shadow store and return the result it causes
    function automatic t_out_item relax_predict(t_in_item it);
        int unsigned       slot;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] word;
        logic [LANE_W-1:0] lane;
        logic [CAND_W-1:0] cand;
        logic [DIST_W-1:0] stored;
        t_out_item         res;
        // below pe_id the slot is set to zero directly, as in the block
        if (it.dest_vertex < VTX_W'(pe_shadow)) begin
            slot = 0;
        end else begin
            slot = (int'(it.dest_vertex) - int'(pe_shadow)) / SLOT_SPAN;
        end
        idx    = slot[IDX_W-1:0];
        word   = ADDR_W'((idx / LANES) % WORDS);
        lane   = LANE_W'(idx % LANES);
        stored = dist_shadow[word][lane*DIST_W +: DIST_W];
        cand   = {1'b0, it.source_distance} + CAND_W'(1);
        res    = '0;
        if (cand < {1'b0, stored}) begin
            dist_shadow[word][lane*DIST_W +: DIST_W] = cand[DIST_W-1:0];
            res.updated      = 1'b1;
            res.new_distance = cand[DIST_W-1:0];
        end
        return res;
    endfunction

    // Receiver: stall at the configured rate
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check each result taken from the block against the oldest prediction
    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_relax.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result updated=%0b new_distance=%0d",
                         $time, out_data.updated, out_data.new_distance);
            end else begin
                want = expected_relax.pop_front();
                if (out_data.updated !== want.updated) begin
                    error_count++;
                    $display("%0t: updated expected %0b actual %0b",
                             $time, want.updated, out_data.updated);
                end
                if (out_data.new_distance !== want.new_distance) begin
                    error_count++;
                    $display("%0t: new_distance expected %0d actual %0d",
                             $time, want.new_distance, out_data.new_distance);
                end
            end
        end
    end

    // Send one item; returns at the edge that accepted it with valid still high
    task automatic send_msg(input logic [DIST_W-1:0] src, input logic [VTX_W-1:0] vtx);
        t_in_item it;
        logic     taken;
        it.source_distance = src;
        it.dest_vertex     = vtx;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !in_stall;
            @(posedge i_clk);
        end
        expected_relax.push_back(relax_predict(it));
    endtask

    // Drop valid and wait until every result has drained
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_relax.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write pe_id while the block is idle
    task automatic write_pe_id(input logic [PE_W-1:0] value);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = cfg_ready;
            @(posedge i_clk);
        end
        cfg_valid <= 1'b0;
        pe_shadow = value;
        @(posedge i_clk);
    endtask

    // Reset and wait out the store clearing sweep
    task automatic test_reset();
        for (int w = 0; w < WORDS; w++) dist_shadow[w] = '1;
        pe_shadow = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (in_stall) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Vertices below pe_id all fold onto slot zero
    task automatic test_below_pe();
        write_pe_id(4'd15);
        send_msg(8'd9, 24'd0);
        send_msg(8'd20, 24'd14);
        send_msg(8'd5, 24'd15);
        send_msg(8'd2, 24'd143);
        send_msg(8'd0, 24'd7);
        drain_results();
    endtask

    // Unreachable source, equal distance and strict improvement
    task automatic test_compare_edges();
        write_pe_id(4'd0);
        send_msg(8'd0, 24'd0);
        send_msg(8'd0, 24'd0);
        send_msg(8'd255, 24'd128);
        send_msg(8'd254, 24'd128);
        send_msg(8'd253, 24'd128);
        send_msg(8'd253, 24'd128);
        send_msg(8'd255, 24'd256);
        send_msg(8'd10, 24'd896);
        send_msg(8'd9, 24'd1023);
    endtask

    // Top vertex id and index wrap onto low words
    task automatic test_aliasing();
        send_msg(8'd100, 24'hFF_FFFF);
        send_msg(8'd99, 24'h7F_FFFF);
        send_msg(8'd0, 24'h80_0000);
        send_msg(8'd3, 24'h40_0000);
        send_msg(8'd1, 24'h40_0080);
        send_msg(8'd50, 24'h00_FFFF);
        send_msg(8'd40, 24'h01_0000 * 8 + 24'd128);
        drain_results();
    endtask

    // Random relaxation traffic around a small set of hot vertices
    task automatic test_random_phase(input int count, input logic [PE_W-1:0] pe,
                                     input int send_pct, input int recv_pct);
        int               pick;
        logic [DIST_W-1:0] src;
        logic [VTX_W-1:0]  vtx;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_pe_id(pe);
        for (int h = 0; h < 16; h++) hot_vertex[h] = VTX_W'($urandom);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                src = DIST_W'($urandom_range(254));
                vtx = VTX_W'($urandom);
            end else if (pick < 75) begin
                src = DIST_W'($urandom_range(60));
                vtx = hot_vertex[$urandom_range(15)];
            end else if (pick < 85) begin
                src = DIST_W'($urandom);
                vtx = VTX_W'($urandom_range(int'(pe)));
            end else if (pick < 92) begin
                src = 8'd255;
                vtx = VTX_W'($urandom);
            end else begin
                src = DIST_W'($urandom);
                vtx = VTX_W'($urandom);
            end
            send_msg(src, vtx);
        end
        drain_results();
    endtask

    initial begin
        send_idle_pct = 8;
        recv_idle_pct = 55;
        test_reset();
        test_below_pe();
        test_compare_edges();
        test_aliasing();
        test_random_phase(250, PE_W'($urandom_range(14, 1)), 8, 55);
        test_random_phase(250, 4'd15, 55, 8);
        test_random_phase(250, 4'd0, 0, 0);
        if (error_count == 0) begin
            $display("bfs_distance_relax_gather_tb OK");
        end else begin
            $display("bfs_distance_relax_gather_tb NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bdrg_pkg.sv
rtl/core/bdrg_ram.sv
rtl/core/bdrg_front.sv
rtl/core/bdrg_queue.sv
rtl/core/bdrg_back.sv
rtl/core/bfs_distance_relax_gather.sv
sim/bfs_distance_relax_gather_tb.sv
